/* hdl/itp_pkg.sv */
// Shared types, character codes and precedence lookup for the infix-to-postfix converter.
// No dependencies; used by itp_front, itp_back and the top level.
package itp_pkg;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;

    // precedence ranks; rank 0 stands for precedence -1
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;
    localparam logic [1:0] RANK_POW  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        K_LETTER,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } t_kind;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expression;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] rank;
        logic [7:0] symbol;
        logic       fin;
    } t_cmd;

    function automatic logic [1:0] prec_rank(input logic [7:0] c);
        logic [1:0] r;
        case (c)
            CH_CARET:           r = RANK_POW;
            CH_STAR, CH_SLASH:  r = RANK_MUL;
            CH_PLUS, CH_MINUS:  r = RANK_ADD;
            default:            r = RANK_NONE;
        endcase
        return r;
    endfunction

endpackage

/* hdl/itp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/itp_front.sv */
// Front end: accepts input characters, classifies them and queues commands (2 entries).
// Depends on itp_pkg.
module itp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  itp_pkg::t_in_item i_in_data,
    output logic              o_cmd_valid,
    output itp_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);

    itp_pkg::t_cmd r_q [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    itp_pkg::t_cmd cmd_in;
    logic          accept;

    always_comb begin
        cmd_in.symbol = i_in_data.symbol;
        cmd_in.fin    = i_in_data.end_of_expression;
        cmd_in.rank   = itp_pkg::prec_rank(i_in_data.symbol);
        if (i_in_data.symbol == itp_pkg::CH_LPAREN) begin
            cmd_in.kind = itp_pkg::K_OPEN;
        end else if (i_in_data.symbol == itp_pkg::CH_RPAREN) begin
            cmd_in.kind = itp_pkg::K_CLOSE;
        end else if (i_in_data.symbol inside {[itp_pkg::CH_LOW_A:itp_pkg::CH_LOW_Z]}) begin
            cmd_in.kind = itp_pkg::K_LETTER;
        end else begin
            cmd_in.kind = itp_pkg::K_OPER;
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (accept) begin
                r_wptr <= !r_wptr;
            end
            if (i_cmd_take) begin
                r_rptr <= !r_rptr;
            end
            case ({accept, i_cmd_take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (accept) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

/* hdl/itp_back.sv */
// Back end: operator stack engine with a one-result hold stage and an output register.
// Depends on itp_pkg and itp_ram (stack storage).
module itp_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  itp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state             r_state, n_state;
    itp_pkg::t_cmd      r_cmd, n_cmd;
    logic               r_main_done, n_main_done;
    logic [CW-1:0]      r_count, n_count;
    logic [7:0]         r_top, n_top;
    itp_pkg::t_out_item r_hold, n_hold;
    logic               r_hold_valid, n_hold_valid;
    itp_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               out_free;
    logic               empty;
    logic               full;
    logic               pop_cond;
    logic               emit_req;
    itp_pkg::t_out_item emit_item;
    logic               do_push;
    logic               do_pop;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    function automatic itp_pkg::t_out_item make_item(input logic [7:0] sym,
                                                     input logic       has,
                                                     input logic [1:0] st);
        itp_pkg::t_out_item it;
        it.out_symbol = sym;
        it.has_symbol = has;
        it.status     = st;
        it.last       = 1'b0;
        return it;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign empty    = (r_count == '0);
    assign full     = (r_count >= DEPTH_C);
    assign pop_cond = (r_cmd.kind == itp_pkg::K_OPER) && !empty
                      && (r_cmd.rank <= itp_pkg::prec_rank(r_top));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_main_done  = r_main_done;
        n_count      = r_count;
        n_top        = r_top;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        o_cmd_take   = 1'b0;
        emit_req     = 1'b0;
        emit_item    = make_item(8'd0, 1'b0, itp_pkg::ST_OK);
        do_push      = 1'b0;
        do_pop       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take  = 1'b1;
                    n_cmd       = i_cmd;
                    n_main_done = 1'b0;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_main_done) begin
                    case (r_cmd.kind)
                        itp_pkg::K_LETTER: begin
                            if (out_free) begin
                                emit_req    = 1'b1;
                                emit_item   = make_item(r_cmd.symbol, 1'b1, itp_pkg::ST_OK);
                                n_main_done = 1'b1;
                            end
                        end
                        itp_pkg::K_OPEN, itp_pkg::K_OPER: begin
                            if (pop_cond) begin
                                if (out_free) begin
                                    emit_req  = 1'b1;
                                    emit_item = make_item(r_top, 1'b1, itp_pkg::ST_OK);
                                    do_pop    = 1'b1;
                                end
                            end else if (full) begin
                                if (out_free) begin
                                    emit_req    = 1'b1;
                                    emit_item   = make_item(8'd0, 1'b0, itp_pkg::ST_OVERFLOW);
                                    n_main_done = 1'b1;
                                end
                            end else begin
                                do_push     = 1'b1;
                                n_main_done = 1'b1;
                            end
                        end
                        itp_pkg::K_CLOSE: begin
                            if (!empty && r_top != itp_pkg::CH_LPAREN) begin
                                if (out_free) begin
                                    emit_req  = 1'b1;
                                    emit_item = make_item(r_top, 1'b1, itp_pkg::ST_OK);
                                    do_pop    = 1'b1;
                                end
                            end else if (!empty) begin
                                do_pop      = 1'b1;
                                n_main_done = 1'b1;
                            end else if (out_free) begin
                                emit_req    = 1'b1;
                                emit_item   = make_item(8'd0, 1'b0, itp_pkg::ST_UNMATCHED);
                                n_main_done = 1'b1;
                            end
                        end
                        default: begin
                            n_main_done = 1'b1;
                        end
                    endcase
                end else if (r_cmd.fin && !empty) begin
                    if (out_free) begin
                        emit_req  = 1'b1;
                        emit_item = make_item(r_top, 1'b1, itp_pkg::ST_OK);
                        do_pop    = 1'b1;
                    end
                end else if (r_cmd.fin) begin
                    if (out_free) begin
                        n_out        = r_hold_valid ? r_hold
                                                    : make_item(8'd0, 1'b0, itp_pkg::ST_OK);
                        n_out.last   = 1'b1;
                        n_out_valid  = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (r_hold_valid) begin
                    if (out_free) begin
                        n_out        = r_hold;
                        n_out_valid  = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_top   = ram_rdata;
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit_req) begin
            if (r_hold_valid) begin
                n_out       = r_hold;
                n_out_valid = 1'b1;
            end
            n_hold       = emit_item;
            n_hold_valid = 1'b1;
        end
        if (do_push) begin
            n_top   = r_cmd.symbol;
            n_count = r_count + CW'(1);
        end
        if (do_pop) begin
            n_count = r_count - CW'(1);
            n_state = S_LOAD;
        end
    end

    // next top lives one entry below the current top
    assign ram_re    = do_pop && (r_count >= CW'(2));
    assign ram_raddr = AW'(r_count - CW'(2));

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (AW'(r_count)),
        .i_wdata (r_cmd.symbol),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_main_done  <= 1'b0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_main_done  <= n_main_done;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_top  <= n_top;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stack count above depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |-> (r_count < DEPTH_C))
        else $error("push into full stack");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("result left in hold stage between items");

    a_last_not_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.status != itp_pkg::ST_OVERFLOW))
        else $error("overflow reported on final transfer");

    a_status_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.has_symbol) |-> (r_out.out_symbol == 8'd0))
        else $error("status-only transfer carries a symbol");

endmodule

/* hdl/infix_to_postfix_converter.sv */
// Infix-to-postfix converter: front classifier/queue, back stack engine, output register.
// A letter passes through the queue, the command register and the hold stage to the output register.
// The back end finishes one character, popping stack entries (a matched '(' too), before it takes the next;
// a full, stalled output register holds the back end while the 2-entry queue takes input.
// Reset (synchronous, active low) empties the queue and the stack; stack RAM is not cleared.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_item o_out_data
);

    logic          cmd_valid;
    itp_pkg::t_cmd cmd;
    logic          cmd_take;

    itp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
